[src/mlsc_pkg.sv]
// ----------------------------------------------------------------------------
// mlsc_pkg
// Shared types and codes for the multi-level sensor calibration block.
// ----------------------------------------------------------------------------
package mlsc_pkg;

    localparam int DATA_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int MODE_W    = 2;
    localparam int CELL_IDX_W = 8;
    localparam int DIV_STEPS = 32;

    // Request modes; the fourth code is unused
    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE  = 2'd0,
        MODE_APPLY  = 2'd1,
        MODE_REMOVE = 2'd2
    } mode_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_DISABLED      = 3'd1,
        ST_NO_POINTS     = 3'd2,
        ST_NO_SEGMENT    = 3'd3,
        ST_LEVEL_MISSING = 3'd4,
        ST_TABLE_FULL    = 3'd5
    } status_t;

    // Source of the result level
    typedef enum logic [2:0] {
        RES_ZERO = 3'd0,
        RES_MIN  = 3'd1,
        RES_MAX  = 3'd2,
        RES_LOW  = 3'd3,
        RES_QUOT = 3'd4
    } res_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic     clr_wr;
        logic     load_in;
        logic     tgt_load;
        logic     alloc;
        logic     remove;
        logic     sweep_wr;
        logic     entry_wr;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     gather_init;
        logic     gather_rd;
        logic     seg_init;
        logic     seg_adv;
        logic     nx_init;
        logic     nx_step;
        logic     mul;
        logic     div_init;
        logic     div_step;
        logic     res_load;
        status_t  res_status;
        res_sel_t res_sel;
        logic     out_load;
    } mlsc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic cnt_at_total;
        logic cnt_at_cells;
        logic cnt_at_slots;
        logic cnt_at_div;
        logic cell_bad;
        logic slot_match;
        logic table_full;
        logic apply_bad;
        logic pts_none;
        logic below_min;
        logic above_max;
        logic seg_hit;
        logic seg_flat;
        logic nxt_is_max;
    } mlsc_stat_t;

endpackage

[src/mlsc_ctrl.sv]
// ----------------------------------------------------------------------------
// mlsc_ctrl
// Sequencer for write, remove and apply requests; owns the output valid.
// ----------------------------------------------------------------------------
module mlsc_ctrl
    import mlsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  mlsc_stat_t stat,
    output mlsc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_SWEEP, S_WR_ENTRY, S_GATHER, S_GATHER_END,
        S_CLAMP, S_NEXT, S_SEG, S_MUL, S_DIV, S_DIV_END, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr  = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_at_total)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.cnt_clr = 1'b1;
                case (stat.mode)
                    MODE_WRITE:
                    begin
                        if (stat.cell_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_NO_POINTS;
                            state_next     = S_OUT;
                        end
                        else if (stat.slot_match)
                        begin
                            cmd.tgt_load = 1'b1;
                            state_next   = S_WR_ENTRY;
                        end
                        else if (stat.table_full)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_TABLE_FULL;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            cmd.tgt_load = 1'b1;
                            cmd.alloc    = 1'b1;
                            state_next   = S_SWEEP;
                        end
                    end
                    MODE_APPLY:
                    begin
                        if (stat.apply_bad)
                        begin
                            cmd.res_load   = 1'b1;
                            cmd.res_status = ST_DISABLED;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            cmd.gather_init = 1'b1;
                            state_next      = S_GATHER;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        cmd.res_load = 1'b1;
                        state_next   = S_OUT;
                        if (stat.slot_match)
                        begin
                            cmd.remove     = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                        else
                        begin
                            cmd.res_status = ST_LEVEL_MISSING;
                        end
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_DISABLED;
                        state_next     = S_OUT;
                    end
                endcase
            end
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_at_cells)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_WR_ENTRY;
                end
            end
            S_WR_ENTRY:
            begin
                cmd.entry_wr   = 1'b1;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_OUT;
            end
            S_GATHER:
            begin
                cmd.gather_rd = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (stat.cnt_at_slots)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_GATHER_END;
                end
            end
            S_GATHER_END:
            begin
                state_next = S_CLAMP;
            end
            S_CLAMP:
            begin
                if (stat.pts_none)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NO_POINTS;
                    state_next     = S_OUT;
                end
                else if (stat.below_min)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_sel    = RES_MIN;
                    state_next     = S_OUT;
                end
                else if (stat.above_max)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_sel    = RES_MAX;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.seg_init = 1'b1;
                    cmd.nx_init  = 1'b1;
                    cmd.cnt_clr  = 1'b1;
                    state_next   = S_NEXT;
                end
            end
            S_NEXT:
            begin
                cmd.nx_step = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.cnt_at_slots)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_SEG;
                end
            end
            S_SEG:
            begin
                if (stat.seg_hit)
                begin
                    if (stat.seg_flat)
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_OK;
                        cmd.res_sel    = RES_LOW;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        cmd.mul    = 1'b1;
                        state_next = S_MUL;
                    end
                end
                else if (stat.nxt_is_max)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = ST_NO_SEGMENT;
                    state_next     = S_OUT;
                end
                else
                begin
                    cmd.seg_adv = 1'b1;
                    cmd.nx_init = 1'b1;
                    cmd.cnt_clr = 1'b1;
                    state_next  = S_NEXT;
                end
            end
            S_MUL:
            begin
                cmd.div_init = 1'b1;
                cmd.cnt_clr  = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.cnt_inc  = 1'b1;
                if (stat.cnt_at_div)
                begin
                    state_next = S_DIV_END;
                end
            end
            S_DIV_END:
            begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_sel    = RES_QUOT;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output word valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[src/mlsc_dp.sv]
// ----------------------------------------------------------------------------
// mlsc_dp
// Slot table, cell point memory, point scan registers and serial divider.
// ----------------------------------------------------------------------------
module mlsc_dp
    import mlsc_pkg::*;
#(
    parameter int MAX_LEVELS = 8,
    parameter int NUM_CELLS  = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic [MODE_W-1:0]     mode,
    input  logic [CELL_IDX_W-1:0] cell_index,
    input  logic [DATA_W-1:0]     level_key,
    input  logic [DATA_W-1:0]     point_value,
    input  logic [DATA_W-1:0]     raw_sample,
    input  mlsc_cmd_t             cmd,
    output mlsc_stat_t            stat,
    output logic [STATUS_W-1:0]   status,
    output logic [DATA_W-1:0]     norm_level
);

    localparam int TOTAL  = MAX_LEVELS * NUM_CELLS;
    localparam int SLOT_W = $clog2(MAX_LEVELS);
    localparam int ADDR_W = $clog2(TOTAL);
    localparam int CNT_W  = $clog2((TOTAL > DIV_STEPS) ? TOTAL : DIV_STEPS);
    localparam int MEM_W  = DATA_W + 1;

    // Request word
    logic [MODE_W-1:0]     mode_reg;
    logic [CELL_IDX_W-1:0] cell_reg;
    logic [DATA_W-1:0]     key_reg;
    logic [DATA_W-1:0]     val_reg;
    logic [DATA_W-1:0]     x_reg;

    logic                  calib_enable_reg;
    logic [DATA_W-1:0]     slot_level_reg [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] slot_used_reg;
    logic [SLOT_W-1:0]     tgt_reg;
    logic [CNT_W-1:0]      cnt_reg;

    // Point memory: {valid, value} per slot and cell
    logic [MEM_W-1:0]      cell_mem [TOTAL];
    logic [MEM_W-1:0]      mem_rdata_reg;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [MEM_W-1:0]      mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;

    // Gathered points
    logic                  rd_pend_reg;
    logic [SLOT_W-1:0]     rd_slot_reg;
    logic [MAX_LEVELS-1:0] pmask_reg;
    logic [DATA_W-1:0]     pval_reg [MAX_LEVELS];
    logic                  have_reg;
    logic                  nx_have_reg;
    logic [DATA_W-1:0]     min_l_reg, min_v_reg, max_l_reg, max_v_reg;
    logic [DATA_W-1:0]     prev_l_reg, prev_v_reg, nxt_l_reg, nxt_v_reg;

    // Divider
    logic [2*DATA_W-1:0]   q_reg;
    logic [DATA_W-1:0]     rem_reg;
    logic [DATA_W-1:0]     den_reg;
    logic [DATA_W:0]       div_trial;
    logic                  div_ge;

    logic [STATUS_W-1:0]   res_status_reg, status_reg;
    logic [DATA_W-1:0]     res_level_reg, norm_reg;
    logic [DATA_W-1:0]     res_level_next;

    logic [MAX_LEVELS-1:0] match_vec;
    logic [SLOT_W-1:0]     match_idx, free_idx;
    logic                  cell_bad;
    logic [SLOT_W-1:0]     rd_idx;
    logic [DATA_W-1:0]     lvl_rd;
    logic [DATA_W-1:0]     dl, dx;

    // Slot lookup
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            match_vec[i] = slot_used_reg[i] && (slot_level_reg[i] == key_reg);
            if (match_vec[i])
            begin
                match_idx = SLOT_W'(i);
            end
            if (!slot_used_reg[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    assign cell_bad = (int'(cell_reg) >= NUM_CELLS);
    assign rd_idx   = rd_pend_reg ? rd_slot_reg : cnt_reg[SLOT_W-1:0];
    assign lvl_rd   = slot_level_reg[rd_idx];

    // Status to the controller
    always_comb
    begin
        stat.mode         = mode_reg;
        stat.cnt_at_total = (cnt_reg == CNT_W'(TOTAL - 1));
        stat.cnt_at_cells = (cnt_reg == CNT_W'(NUM_CELLS - 1));
        stat.cnt_at_slots = (cnt_reg == CNT_W'(MAX_LEVELS - 1));
        stat.cnt_at_div   = (cnt_reg == CNT_W'(DIV_STEPS - 1));
        stat.cell_bad     = cell_bad;
        stat.slot_match   = |match_vec;
        stat.table_full   = &slot_used_reg;
        stat.apply_bad    = !calib_enable_reg || !(|slot_used_reg) || cell_bad;
        stat.pts_none     = !have_reg;
        stat.below_min    = (x_reg <= min_v_reg);
        stat.above_max    = (x_reg >= max_v_reg);
        stat.seg_hit      = (x_reg >= prev_v_reg) && (x_reg <= nxt_v_reg);
        stat.seg_flat     = (prev_v_reg == nxt_v_reg);
        stat.nxt_is_max   = (nxt_l_reg == max_l_reg);
    end

    // Memory port select
    always_comb
    begin
        mem_we    = cmd.clr_wr || cmd.sweep_wr || cmd.entry_wr;
        mem_waddr = cnt_reg[ADDR_W-1:0];
        mem_wdata = '0;
        if (cmd.sweep_wr)
        begin
            mem_waddr = ADDR_W'(int'(tgt_reg) * NUM_CELLS + int'(cnt_reg));
        end
        else if (cmd.entry_wr)
        begin
            mem_waddr = ADDR_W'(int'(tgt_reg) * NUM_CELLS + int'(cell_reg));
            mem_wdata = {1'b1, val_reg};
        end
        mem_raddr = ADDR_W'(int'(cnt_reg[SLOT_W-1:0]) * NUM_CELLS + int'(cell_reg));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= cell_mem[mem_raddr];
    end

    // Divider step and interpolation terms
    assign div_trial = {rem_reg, q_reg[2*DATA_W-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});
    assign dl        = nxt_l_reg - prev_l_reg;
    assign dx        = x_reg - prev_v_reg;

    always_comb
    begin
        case (cmd.res_sel)
            RES_MIN:  res_level_next = min_l_reg;
            RES_MAX:  res_level_next = max_l_reg;
            RES_LOW:  res_level_next = prev_l_reg;
            RES_QUOT: res_level_next = prev_l_reg + q_reg[DATA_W-1:0];
            default:  res_level_next = '0;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_enable_reg <= 1'b0;
            slot_used_reg    <= '0;
            cnt_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            pmask_reg        <= '0;
            have_reg         <= 1'b0;
            nx_have_reg      <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                slot_level_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                calib_enable_reg <= cfg_wdata;
            end
            if (cmd.alloc)
            begin
                slot_used_reg[free_idx]  <= 1'b1;
                slot_level_reg[free_idx] <= key_reg;
            end
            if (cmd.remove)
            begin
                slot_used_reg[match_idx] <= 1'b0;
            end
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_pend_reg <= cmd.gather_rd;
            if (cmd.gather_init)
            begin
                pmask_reg <= '0;
                have_reg  <= 1'b0;
            end
            else if (rd_pend_reg && mem_rdata_reg[DATA_W] && slot_used_reg[rd_idx])
            begin
                pmask_reg[rd_idx] <= 1'b1;
                have_reg          <= 1'b1;
            end
            if (cmd.nx_init)
            begin
                nx_have_reg <= 1'b0;
            end
            else if (cmd.nx_step && pmask_reg[rd_idx] && (lvl_rd > prev_l_reg)
                     && (!nx_have_reg || lvl_rd < nxt_l_reg))
            begin
                nx_have_reg <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            cell_reg <= cell_index;
            key_reg  <= level_key;
            val_reg  <= point_value;
            x_reg    <= raw_sample;
        end
        if (cmd.tgt_load)
        begin
            tgt_reg <= (|match_vec) ? match_idx : free_idx;
        end
        if (cmd.gather_rd)
        begin
            rd_slot_reg <= cnt_reg[SLOT_W-1:0];
        end
        // Capture a valid point and track the lowest and highest levels
        if (rd_pend_reg && mem_rdata_reg[DATA_W] && slot_used_reg[rd_idx])
        begin
            pval_reg[rd_idx] <= mem_rdata_reg[DATA_W-1:0];
            if (!have_reg || lvl_rd < min_l_reg)
            begin
                min_l_reg <= lvl_rd;
                min_v_reg <= mem_rdata_reg[DATA_W-1:0];
            end
            if (!have_reg || lvl_rd > max_l_reg)
            begin
                max_l_reg <= lvl_rd;
                max_v_reg <= mem_rdata_reg[DATA_W-1:0];
            end
        end
        // Segment walk
        if (cmd.seg_init)
        begin
            prev_l_reg <= min_l_reg;
            prev_v_reg <= min_v_reg;
        end
        else if (cmd.seg_adv)
        begin
            prev_l_reg <= nxt_l_reg;
            prev_v_reg <= nxt_v_reg;
        end
        if (cmd.nx_step && pmask_reg[rd_idx] && (lvl_rd > prev_l_reg)
            && (!nx_have_reg || lvl_rd < nxt_l_reg))
        begin
            nxt_l_reg <= lvl_rd;
            nxt_v_reg <= pval_reg[rd_idx];
        end
        // Product, then restoring division one bit a cycle
        if (cmd.mul)
        begin
            q_reg   <= {{DATA_W{1'b0}}, dl} * {{DATA_W{1'b0}}, dx};
            den_reg <= nxt_v_reg - prev_v_reg;
        end
        else if (cmd.div_step)
        begin
            q_reg <= {q_reg[2*DATA_W-2:0], div_ge};
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= div_ge ? DATA_W'(div_trial - {1'b0, den_reg}) : div_trial[DATA_W-1:0];
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_level_reg  <= res_level_next;
        end
        if (cmd.out_load)
        begin
            status_reg <= res_status_reg;
            norm_reg   <= res_level_reg;
        end
    end

    assign status     = status_reg;
    assign norm_level = norm_reg;

    // Checks
    a_mem_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clr_wr, cmd.sweep_wr, cmd.entry_wr}))
        else $error("more than one memory write source");

    a_entry_slot_used: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.entry_wr |-> (slot_used_reg[tgt_reg] && !cell_bad))
        else $error("point written to a free slot or a bad cell");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && cmd.res_sel == RES_QUOT) |-> (q_reg[2*DATA_W-1:DATA_W] == '0))
        else $error("interpolation quotient overflow");

endmodule

[src/multi_level_sensor_calibration_top.sv]
// ----------------------------------------------------------------------------
// multi_level_sensor_calibration_top
// Per-cell piecewise linear calibration over up to MAX_LEVELS reference levels.
// ----------------------------------------------------------------------------
// After reset the point memory is cleared one entry a cycle, all MAX_LEVELS *
// NUM_CELLS entries, with in_ready low. One request is worked at a time. A
// write to a known level passes decode and the entry write, and a remove is
// settled in decode; a write that opens a new level first sweeps that level's
// row of NUM_CELLS entries. An apply reads the cell's points over the
// MAX_LEVELS slots, then walks the segments in level order with one slot scan
// per segment, and interpolates with a 16x16 multiply and a bit-serial
// restoring divider; a sample that clamps skips the walk. The result word
// sits in an output register, so the next request is taken while it waits.
// ----------------------------------------------------------------------------
module multi_level_sensor_calibration_top
    import mlsc_pkg::*;
#(
    parameter int MAX_LEVELS = 8,
    parameter int NUM_CELLS  = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [MODE_W-1:0]     mode,
    input  logic [CELL_IDX_W-1:0] cell_index,
    input  logic [DATA_W-1:0]     level_key,
    input  logic [DATA_W-1:0]     point_value,
    input  logic [DATA_W-1:0]     raw_sample,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STATUS_W-1:0]   status,
    output logic [DATA_W-1:0]     norm_level
);

    mlsc_cmd_t  cmd;
    mlsc_stat_t stat;

    // Sequencer
    mlsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Table and arithmetic
    mlsc_dp #(
        .MAX_LEVELS (MAX_LEVELS),
        .NUM_CELLS  (NUM_CELLS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mode        (mode),
        .cell_index  (cell_index),
        .level_key   (level_key),
        .point_value (point_value),
        .raw_sample  (raw_sample),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .norm_level  (norm_level)
    );

endmodule
